// ===== rtl/rhc_pkg.sv =====
// Shared types, constants and divider step functions for the RGB to HSL converter.
// No dependencies.
package rhc_pkg;

    localparam int ChanW    = 8;
    localparam int OutW     = 13;
    localparam int DvdW     = 21;
    localparam int DenW     = 9;
    localparam int QuoW     = 13;
    localparam int DivSteps = QuoW;
    localparam int LitW     = 13;

    localparam logic [OutW-1:0] HueFull     = 13'd5760;
    localparam logic [OutW-1:0] HueOfsRed   = 13'd4800;
    localparam logic [OutW-1:0] HueOfsGreen = 13'd960;
    localparam logic [OutW-1:0] HueOfsBlue  = 13'd2880;
    localparam logic [OutW-1:0] OneFix      = 13'd4096;

    typedef enum logic [1:0] {
        SEL_RED,
        SEL_GREEN,
        SEL_BLUE
    } maxsel_t;

    // restoring divider state: partial remainder, dividend bits / quotient, divisor
    typedef struct packed {
        logic [DenW-1:0] rem;
        logic [QuoW-1:0] dvd;
        logic [DenW-1:0] den;
    } div_t;

    typedef struct packed {
        logic [ChanW-1:0] r;
        logic [ChanW-1:0] g;
        logic [ChanW-1:0] b;
        logic [ChanW-1:0] mx;
        logic [ChanW-1:0] mn;
        maxsel_t          sel;
    } pix_t;

    typedef struct packed {
        logic [ChanW-1:0] d;
        logic [ChanW:0]   sum;
        logic [ChanW:0]   t;
        logic [ChanW-1:0] den;
        logic [LitW-1:0]  lr;
        maxsel_t          sel;
        logic             grey;
    } prep_t;

    typedef struct packed {
        div_t            hdiv;
        div_t            sdiv;
        logic [OutW-1:0] ofs;
        logic [OutW-1:0] lit;
        logic            grey;
    } work_t;

    // quotient must fit in QuoW bits, so the top dividend bits stay below the divisor
    function automatic div_t div_init(logic [DvdW-1:0] n, logic [DenW-1:0] dn);
        div_t x;
        x.rem = DenW'(n[DvdW-1:QuoW]);
        x.dvd = n[QuoW-1:0];
        x.den = dn;
        return x;
    endfunction

    function automatic div_t div_step(div_t x);
        div_t            y;
        logic [DenW:0]   cand;
        logic            qbit;
        cand = {x.rem, x.dvd[QuoW-1]};
        qbit = (cand >= {1'b0, x.den});
        y.rem = qbit ? DenW'(cand - {1'b0, x.den}) : cand[DenW-1:0];
        y.dvd = {x.dvd[QuoW-2:0], qbit};
        y.den = x.den;
        return y;
    endfunction

    function automatic work_t work_step(work_t x);
        work_t y;
        y      = x;
        y.hdiv = div_step(x.hdiv);
        y.sdiv = div_step(x.sdiv);
        return y;
    endfunction

endpackage

// ===== rtl/rgb_to_hsl_converter.sv =====
// RGB to HSL converter: pipelined min/max, prep, two restoring dividers.
// Depends on rhc_pkg.
//
// Converts 8-bit RGB pixels into hue (1/16 degree, 0..5759),
// saturation and lightness (4096 = 1.0), all rounded half up. Each pixel
// passes through three preparation stages, thirteen divider stages (one
// quotient bit per stage for the hue and saturation quotients) and the
// output register. A full pipeline sustains one beat per cycle while the
// output is not stalled; when the output is stalled, empty stages still
// fill, so in_ready drops only once every stage holds a pixel.
module rgb_to_hsl_converter
    import rhc_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [ChanW-1:0] red,
    input  logic [ChanW-1:0] green,
    input  logic [ChanW-1:0] blue,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [OutW-1:0]  hue,
    output logic [OutW-1:0]  saturation,
    output logic [OutW-1:0]  lightness
);

    localparam int StageCnt = 3 + DivSteps;

    logic [StageCnt-1:0] v_reg;
    logic [StageCnt-1:0] v_next;
    logic [StageCnt:0]   en;

    pix_t  s1_reg, s1_next;
    prep_t s2_reg, s2_next;
    work_t s3_reg, s3_next;
    work_t div_reg  [DivSteps];
    work_t div_next [DivSteps];

    logic            out_valid_reg;
    logic [OutW-1:0] hue_reg, hue_next;
    logic [OutW-1:0] sat_reg, sat_next;
    logic [OutW-1:0] lit_reg, lit_next;

    // stall chain: a stage moves when it is empty or the one after it moves
    always_comb
    begin
        en[StageCnt] = !out_valid_reg || out_ready;
        for (int i = StageCnt - 1; i >= 0; i--)
        begin
            en[i] = !v_reg[i] || en[i+1];
        end
        v_next = {v_reg[StageCnt-2:0], in_valid};
    end

    assign in_ready = en[0];

    // stage 1: max, min and which channel is the max
    always_comb
    begin
        s1_next.r = red;
        s1_next.g = green;
        s1_next.b = blue;
        if (red >= green && red >= blue)
        begin
            s1_next.sel = SEL_RED;
            s1_next.mx  = red;
        end
        else if (green >= blue)
        begin
            s1_next.sel = SEL_GREEN;
            s1_next.mx  = green;
        end
        else
        begin
            s1_next.sel = SEL_BLUE;
            s1_next.mx  = blue;
        end
        s1_next.mn = red;
        if (green < s1_next.mn)
        begin
            s1_next.mn = green;
        end
        if (blue < s1_next.mn)
        begin
            s1_next.mn = blue;
        end
    end

    // stage 2: range, sum, hue numerator term, saturation denominator
    always_comb
    begin
        logic [ChanW+1:0] t_w;
        s2_next.d    = s1_reg.mx - s1_reg.mn;
        s2_next.sum  = {1'b0, s1_reg.mx} + {1'b0, s1_reg.mn};
        s2_next.grey = (s2_next.d == '0);
        s2_next.sel  = s1_reg.sel;
        case (s1_reg.sel)
            SEL_RED:
                t_w = (ChanW+2)'(s1_reg.g) + (ChanW+2)'(s2_next.d) - (ChanW+2)'(s1_reg.b);
            SEL_GREEN:
                t_w = (ChanW+2)'(s1_reg.b) + (ChanW+2)'(s2_next.d) - (ChanW+2)'(s1_reg.r);
            SEL_BLUE:
                t_w = (ChanW+2)'(s1_reg.r) + (ChanW+2)'(s2_next.d) - (ChanW+2)'(s1_reg.g);
            default:
                t_w = '0;
        endcase
        s2_next.t   = t_w[ChanW:0];
        s2_next.den = (s2_next.sum <= 9'd255) ? s2_next.sum[ChanW-1:0]
                                              : ChanW'(10'd510 - {1'b0, s2_next.sum});
        s2_next.lr  = (LitW'(s2_next.sum) << 3) + LitW'(127);
    end

    // stage 3: divider operands, hue offset, lightness by reciprocal of 255
    always_comb
    begin
        logic [DvdW-1:0] n_hue;
        logic [DvdW-1:0] n_sat;
        logic [20:0]     prod;
        logic [4:0]      q0;
        logic [LitW-1:0] lrem;
        logic [4:0]      q;
        n_hue = (DvdW'(s2_reg.t) << 11) - (DvdW'(s2_reg.t) << 7) + DvdW'(s2_reg.d);
        n_sat = (DvdW'(s2_reg.d) << 13) + DvdW'(s2_reg.den);
        s3_next.hdiv = div_init(n_hue, {s2_reg.d, 1'b0});
        s3_next.sdiv = div_init(n_sat, {s2_reg.den, 1'b0});
        prod = (21'(s2_reg.lr) << 8) + 21'(s2_reg.lr);
        q0   = prod[20:16];
        lrem = s2_reg.lr - ((LitW'(q0) << 8) - LitW'(q0));
        q    = (lrem >= LitW'(255)) ? q0 + 5'd1 : q0;
        s3_next.lit  = (OutW'(s2_reg.sum) << 3) + OutW'(q);
        s3_next.grey = s2_reg.grey;
        case (s2_reg.sel)
            SEL_RED:   s3_next.ofs = HueOfsRed;
            SEL_GREEN: s3_next.ofs = HueOfsGreen;
            SEL_BLUE:  s3_next.ofs = HueOfsBlue;
            default:   s3_next.ofs = '0;
        endcase
    end

    always_comb
    begin
        div_next[0] = work_step(s3_reg);
        for (int k = 1; k < DivSteps; k++)
        begin
            div_next[k] = work_step(div_reg[k-1]);
        end
    end

    // output: add hue offset, wrap full circle, zero hue and saturation on grey
    always_comb
    begin
        logic [OutW:0] hsum;
        hsum = (OutW+1)'(div_reg[DivSteps-1].ofs) + (OutW+1)'(div_reg[DivSteps-1].hdiv.dvd);
        if (hsum >= (OutW+1)'(HueFull))
        begin
            hsum = hsum - (OutW+1)'(HueFull);
        end
        hue_next = div_reg[DivSteps-1].grey ? '0 : hsum[OutW-1:0];
        sat_next = div_reg[DivSteps-1].grey ? '0 : div_reg[DivSteps-1].sdiv.dvd;
        lit_next = div_reg[DivSteps-1].lit;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg         <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            for (int i = 0; i < StageCnt; i++)
            begin
                if (en[i])
                begin
                    v_reg[i] <= v_next[i];
                end
            end
            if (en[StageCnt])
            begin
                out_valid_reg <= v_reg[StageCnt-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            s1_reg <= s1_next;
        end
        if (en[1])
        begin
            s2_reg <= s2_next;
        end
        if (en[2])
        begin
            s3_reg <= s3_next;
        end
        for (int k = 0; k < DivSteps; k++)
        begin
            if (en[3+k])
            begin
                div_reg[k] <= div_next[k];
            end
        end
        if (en[StageCnt])
        begin
            hue_reg <= hue_next;
            sat_reg <= sat_next;
            lit_reg <= lit_next;
        end
    end

    assign out_valid  = out_valid_reg;
    assign hue        = hue_reg;
    assign saturation = sat_reg;
    assign lightness  = lit_reg;

    a_hue_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> hue < HueFull)
        else $error("hue out of range");

    a_frac_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (saturation <= OneFix && lightness <= OneFix))
        else $error("saturation or lightness above one");

    a_ready_empty_out: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input stalled with empty output");

endmodule

// ===== bench/rgb_to_hsl_converter_tb.sv =====
// Testbench for rgb_to_hsl_converter: directed and random pixels, with beats
// checked against a built-in fixed-point HSL predictor. Depends on rhc_pkg.
`timescale 1ns / 100ps

module rgb_to_hsl_converter_tb;
    import rhc_pkg::*;

    localparam int WatchdogLimit = 2000;
    localparam int TailCycles    = 40;

    typedef struct packed {
        logic [OutW-1:0] hue;
        logic [OutW-1:0] sat;
        logic [OutW-1:0] lit;
    } hsl_t;

    logic             clk = 1'b0;
    logic             rst_n = 1'b0;
    logic             in_valid = 1'b0;
    logic             in_ready;
    logic [ChanW-1:0] red = '0;
    logic [ChanW-1:0] green = '0;
    logic [ChanW-1:0] blue = '0;
    logic             out_valid;
    logic             out_ready = 1'b0;
    logic [OutW-1:0]  hue;
    logic [OutW-1:0]  saturation;
    logic [OutW-1:0]  lightness;

    hsl_t hsl_expected[$];
    hsl_t hsl_want;
    int   error_count = 0;
    int   stuck_cycles = 0;
    int   send_idle_pct = 0;
    int   recv_idle_pct = 0;

    rgb_to_hsl_converter u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .red        (red),
        .green      (green),
        .blue       (blue),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .hue        (hue),
        .saturation (saturation),
        .lightness  (lightness)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic int unsigned round_half_up(int unsigned num, int unsigned den);
        return (2 * num + den) / (2 * den);
    endfunction

    function automatic hsl_t predict_hsl(logic [ChanW-1:0] r, logic [ChanW-1:0] g,
                                         logic [ChanW-1:0] b);
        int   mx;
        int   mn;
        int   d;
        int   sum;
        int   scaled;
        int   h;
        hsl_t res;
        mx  = (r >= g) ? ((r >= b) ? r : b) : ((g >= b) ? g : b);
        mn  = (r <= g) ? ((r <= b) ? r : b) : ((g <= b) ? g : b);
        d   = mx - mn;
        sum = mx + mn;
        res = '0;
        if (d != 0)
        begin
            // hue scaled by d, in 1/16 degree; red wins ties, then green
            if (r == mx)
                scaled = 960 * (int'(g) - int'(b)) + 5760 * d;
            else if (g == mx)
                scaled = 960 * (int'(b) - int'(r)) + 1920 * d;
            else
                scaled = 960 * (int'(r) - int'(g)) + 3840 * d;
            h = round_half_up(scaled, d);
            if (h >= int'(HueFull))
                h -= int'(HueFull);
            res.hue = OutW'(h);
            res.sat = OutW'(round_half_up(int'(OneFix) * d,
                                          (sum <= 255) ? sum : 510 - sum));
        end
        res.lit = OutW'(round_half_up(int'(OneFix) * sum, 510));
        return res;
    endfunction

    function automatic logic [ChanW-1:0] rail_value();
        logic [1:0] k;
        k = 2'($urandom_range(3));
        return k[1] ? (k[0] ? 8'd255 : 8'd254) : (k[0] ? 8'd1 : 8'd0);
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        error_count++;
    endtask

    task automatic send_pixel(input logic [ChanW-1:0] r, input logic [ChanW-1:0] g,
                              input logic [ChanW-1:0] b);
        int gap;
        gap = 0;
        while ($urandom_range(99) < send_idle_pct)
            gap++;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        red      <= r;
        green    <= g;
        blue     <= b;
        do
            @(posedge clk);
        while (!in_ready);
        hsl_expected.push_back(predict_hsl(r, g, b));
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (hsl_expected.size() != 0)
            @(posedge clk);
    endtask

    task automatic pick_pixel(output logic [ChanW-1:0] r, output logic [ChanW-1:0] g,
                              output logic [ChanW-1:0] b);
        int               kind;
        logic [ChanW-1:0] hi;
        logic [ChanW-1:0] lo;
        logic [ChanW-1:0] mid;
        kind = $urandom_range(99);
        r    = ChanW'($urandom);
        g    = ChanW'($urandom);
        b    = ChanW'($urandom);
        if (kind < 12)
        begin
            g = r;
            b = r;
        end
        else if (kind < 27)
        begin
            case ($urandom_range(2))
                0: g = r;
                1: b = g;
                default: b = r;
            endcase
        end
        else if (kind < 40)
        begin
            // max + min around the saturation fold at 255
            hi  = ChanW'($urandom_range(128, 255));
            lo  = ChanW'(9'd255 - hi + ChanW'($urandom_range(2)) - 1);
            mid = (hi > lo) ? ChanW'($urandom_range(lo, hi)) : ChanW'($urandom_range(hi, lo));
            case ($urandom_range(2))
                0: begin r = hi;  g = lo;  b = mid; end
                1: begin r = mid; g = hi;  b = lo;  end
                default: begin r = lo; g = mid; b = hi; end
            endcase
        end
        else if (kind < 50)
        begin
            r = rail_value();
            g = rail_value();
            b = rail_value();
        end
    endtask

    task automatic test_grey_levels();
        send_pixel(8'd0, 8'd0, 8'd0);
        send_pixel(8'd255, 8'd255, 8'd255);
        send_pixel(8'd128, 8'd128, 8'd128);
        send_pixel(8'd1, 8'd1, 8'd1);
    endtask

    task automatic test_primaries();
        send_pixel(8'd255, 8'd0, 8'd0);
        send_pixel(8'd0, 8'd255, 8'd0);
        send_pixel(8'd0, 8'd0, 8'd255);
        send_pixel(8'd255, 8'd255, 8'd0);
        send_pixel(8'd0, 8'd255, 8'd255);
        send_pixel(8'd255, 8'd0, 8'd255);
    endtask

    task automatic test_max_ties();
        send_pixel(8'd200, 8'd200, 8'd50);
        send_pixel(8'd50, 8'd200, 8'd200);
        send_pixel(8'd200, 8'd50, 8'd200);
    endtask

    task automatic test_hue_wrap();
        send_pixel(8'd255, 8'd10, 8'd0);
        send_pixel(8'd255, 8'd0, 8'd1);
        send_pixel(8'd1, 8'd0, 8'd0);
        send_pixel(8'd254, 8'd253, 8'd253);
    endtask

    task automatic test_sat_fold();
        send_pixel(8'd200, 8'd55, 8'd100);
        send_pixel(8'd200, 8'd56, 8'd100);
        send_pixel(8'd128, 8'd127, 8'd127);
        send_pixel(8'd127, 8'd128, 8'd0);
    endtask

    task automatic test_random_pixels(input int send_pct, input int recv_pct, input int count);
        logic [ChanW-1:0] r;
        logic [ChanW-1:0] g;
        logic [ChanW-1:0] b;
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        repeat (count)
        begin
            pick_pixel(r, g, b);
            send_pixel(r, g, b);
        end
    endtask

    always @(posedge clk)
        out_ready <= ($urandom_range(99) >= recv_idle_pct);

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (hsl_expected.size() == 0)
                report_mismatch("beat with nothing pending, hue", hue, -1);
            else
            begin
                hsl_want = hsl_expected.pop_front();
                if (hue !== hsl_want.hue)
                    report_mismatch("hue", hue, hsl_want.hue);
                if (saturation !== hsl_want.sat)
                    report_mismatch("saturation", saturation, hsl_want.sat);
                if (lightness !== hsl_want.lit)
                    report_mismatch("lightness", lightness, hsl_want.lit);
            end
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || !rst_n)
            stuck_cycles <= 0;
        else
        begin
            stuck_cycles <= stuck_cycles + 1;
            if (stuck_cycles >= WatchdogLimit)
            begin
                $display("watchdog: no beat for %0d cycles", WatchdogLimit);
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_idle_pct = 27;
        recv_idle_pct = 48;
        test_grey_levels();
        test_primaries();
        test_max_ties();
        test_hue_wrap();
        test_sat_fold();

        test_random_pixels(27, 48, 220);
        wait_drained();
        test_random_pixels(48, 27, 220);
        wait_drained();
        test_random_pixels(0, 0, 210);

        in_valid <= 1'b0;
        while (hsl_expected.size() != 0)
            @(posedge clk);
        repeat (TailCycles) @(posedge clk);
        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
